@@ design/pau_pkg.sv @@
`default_nettype none

package pau_pkg;

	// Most result items one input item can produce
	localparam int unsigned RES_MAX = 5;
	localparam int unsigned RES_CNT_W = $clog2(RES_MAX + 1);

	localparam logic [7:0] CH_PCT  = 8'h25;   // '%'
	localparam logic [7:0] CH_AMP  = 8'h26;   // '&'
	localparam logic [7:0] CH_ZERO = 8'h30;   // '0'
	localparam logic [7:0] CH_NINE = 8'h39;   // '9'
	localparam logic [7:0] HEX_LC_BASE = 8'h57; // 'a' - 10
	localparam logic [7:0] LC_BIT = 8'h20;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_PCT  = 2'd1,
		KIND_AMP  = 2'd2
	} pau_kind_t;

	typedef struct packed {
		logic [7:0] in_char;
		logic       in_last;
	} pau_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} pau_out_t;

	// Pending escape sequence
	typedef struct packed {
		pau_kind_t  kind;
		logic [1:0] matched;  // hex digits after '%', or chars of "amp;" after '&'
		logic [7:0] held;     // first hex digit after '%'
	} pau_state_t;

	localparam pau_state_t STATE_CLEAR = '{kind: KIND_NONE, matched: 2'd0, held: 8'd0};

	// Characters that must follow '&' to form "&amp;"
	function automatic logic [7:0] amp_tail(input logic [1:0] idx);
		logic [7:0] ch;
		unique case (idx)
			2'd0:    ch = 8'h61;  // 'a'
			2'd1:    ch = 8'h6d;  // 'm'
			2'd2:    ch = 8'h70;  // 'p'
			default: ch = 8'h3b;  // ';'
		endcase
		return ch;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
		       ((c >= 8'h61) && (c <= 8'h66)) ||
		       ((c >= 8'h41) && (c <= 8'h46));
	endfunction

	function automatic logic [3:0] nib_value(input logic [7:0] c);
		logic [7:0] t;
		if (c <= CH_NINE) begin
			t = c - CH_ZERO;
		end else begin
			t = (c | LC_BIT) - HEX_LC_BASE;
		end
		return t[3:0];
	endfunction

endpackage

`default_nettype wire

@@ design/pau_step.sv @@
`default_nettype none

// Decode of one item against the pending sequence: result list and next state
module pau_step
	import pau_pkg::*;
(
	input  wire pau_state_t                 state,
	input  wire pau_in_t                    item,
	output pau_state_t                      state_nxt,
	output pau_out_t [RES_MAX-1:0]          res,
	output logic [RES_CNT_W-1:0]            res_cnt
);

	logic [7:0]           c;
	logic                 last;
	logic                 pct_hex;
	logic                 amp_match;
	logic                 complete;
	logic                 cont;
	logic                 special;
	logic                 pending;
	logic [RES_CNT_W-1:0] n0;
	logic [7:0]           decoded;
	logic [7:0]           slot;

	assign c    = item.in_char;
	assign last = item.in_last;

	// Classify the item against what is pending
	always_comb begin
		pending   = (state.kind == KIND_PCT) || (state.kind == KIND_AMP);
		pct_hex   = (state.kind == KIND_PCT) && is_hex(c);
		amp_match = (state.kind == KIND_AMP) && (c == amp_tail(state.matched));
		complete  = (pct_hex && (state.matched != 2'd0)) ||
		            (amp_match && (state.matched == 2'd3));
		cont      = (pct_hex && (state.matched == 2'd0)) ||
		            (amp_match && (state.matched != 2'd3));
		special   = (c == CH_PCT) || (c == CH_AMP);
		n0        = pending ? (RES_CNT_W'(state.matched) + RES_CNT_W'(1)) : '0;
		decoded   = {nib_value(state.held), nib_value(c)};
	end

	// Result count and next state
	always_comb begin
		state_nxt = STATE_CLEAR;
		if (complete) begin
			res_cnt = RES_CNT_W'(1);
		end else if (cont) begin
			res_cnt = last ? (n0 + RES_CNT_W'(1)) : '0;
			if (!last) begin
				state_nxt.kind    = state.kind;
				state_nxt.matched = state.matched + 2'd1;
				state_nxt.held    = (state.kind == KIND_PCT) ? c : state.held;
			end
		end else begin
			// mismatch or nothing pending: held bytes, then the item afresh
			res_cnt = (!special || last) ? (n0 + RES_CNT_W'(1)) : n0;
			if (special && !last) begin
				state_nxt.kind = (c == CH_PCT) ? KIND_PCT : KIND_AMP;
			end
		end
	end

	// Result slots: decoded byte, or held bytes in arrival order, then the item
	always_comb begin
		for (int i = 0; i < RES_MAX; i++) begin
			if (complete) begin
				slot = (state.kind == KIND_PCT) ? decoded : CH_AMP;
			end else if (RES_CNT_W'(i) >= n0) begin
				slot = c;
			end else if (i == 0) begin
				slot = (state.kind == KIND_PCT) ? CH_PCT : CH_AMP;
			end else begin
				slot = (state.kind == KIND_PCT) ? state.held : amp_tail(2'(i - 1));
			end
			res[i].out_byte = slot;
			res[i].out_last = last && (RES_CNT_W'(i) == (res_cnt - RES_CNT_W'(1)));
		end
	end

endmodule

`default_nettype wire

@@ design/percent_and_amp_unescaper_unit.sv @@
`default_nettype none

// Channel  | Signals                       | Item
// ---------+-------------------------------+----------------------------
// src      | src_valid src_ready src_data  | pau_in_t  {in_char, in_last}
// dst      | dst_valid dst_ready dst_data  | pau_out_t {out_byte, out_last}
//
// One item per cycle while each item yields at most one result byte.
// An item yielding n results (up to 5, on a mismatch flush) holds the
// decode stage while the result buffer drains, one byte per dst handshake.
// Reset clears the pending sequence and both stages; no clearing pass.
// dst stalls back up through the decode stage to src_ready.
module percent_and_amp_unescaper_unit
	import pau_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        src_valid,
	output logic       src_ready,
	input  wire pau_in_t  src_data,
	output logic       dst_valid,
	input  wire        dst_ready,
	output pau_out_t   dst_data
);

	logic                 valid_s1;
	pau_in_t              item_s1;
	pau_state_t           state_q;
	pau_state_t           state_nxt;
	pau_out_t [RES_MAX-1:0] res;
	logic [RES_CNT_W-1:0] res_cnt;
	pau_out_t             rbuf_q [RES_MAX];
	logic [RES_CNT_W-1:0] cnt_q;
	logic                 pop;
	logic                 consume;

	// Decode logic
	pau_step u_step (
		.state     (state_q),
		.item      (item_s1),
		.state_nxt (state_nxt),
		.res       (res),
		.res_cnt   (res_cnt)
	);

	// Handshake
	assign pop       = dst_valid && dst_ready;
	assign consume   = valid_s1 && ((cnt_q == '0) || ((cnt_q == RES_CNT_W'(1)) && dst_ready));
	assign src_ready = !valid_s1 || consume;
	assign dst_valid = (cnt_q != '0);
	assign dst_data  = rbuf_q[0];

	// Input stage and pending-sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= STATE_CLEAR;
		end else begin
			if (src_ready) begin
				valid_s1 <= src_valid;
			end
			if (consume) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && src_ready) begin
			item_s1 <= src_data;
		end
	end

	// Result buffer: load a whole list, shift out one item per pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (consume) begin
			cnt_q <= res_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - RES_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (consume) begin
			for (int i = 0; i < RES_MAX; i++) begin
				rbuf_q[i] <= res[i];
			end
		end else if (pop) begin
			for (int i = 0; i < RES_MAX - 1; i++) begin
				rbuf_q[i] <= rbuf_q[i+1];
			end
		end
	end

	// Checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= RES_CNT_W'(RES_MAX))
		else $error("result buffer count out of range");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !consume |=> valid_s1 && $stable(item_s1))
		else $error("decode stage item lost while stalled");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		consume && item_s1.in_last |=> state_q.kind == KIND_NONE)
		else $error("pending sequence survives final item");

	a_pct_depth: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.kind == KIND_PCT |-> state_q.matched <= 2'd1)
		else $error("more than one hex digit held");

endmodule

`default_nettype wire
